### rtl/sjph_pkg.sv
// ----------------------------------------------------------------------------
// sjph_pkg
// Shared types, constants and character helpers for the SJIS PJW
// bucket hash unit.
// ----------------------------------------------------------------------------
package sjph_pkg;

   localparam int unsigned HASH_W    = 32;
   localparam int unsigned BUCKET_W  = 31;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned CHAR_W    = 16;
   localparam int unsigned DIV_STEPS = HASH_W;
   localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

   localparam logic [BUCKET_W-1:0] RESET_BUCKETS = 31'd127;

   localparam logic [BYTE_W-1:0] LEAD_LO_A = 8'h81;
   localparam logic [BYTE_W-1:0] LEAD_HI_A = 8'h9F;
   localparam logic [BYTE_W-1:0] LEAD_LO_B = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD_HI_B = 8'hFC;
   localparam logic [BYTE_W-1:0] UPPER_LO  = 8'h41;
   localparam logic [BYTE_W-1:0] UPPER_HI  = 8'h5A;
   localparam logic [BYTE_W-1:0] CASE_OFS  = 8'h20;

   // Controller to datapath
   typedef struct packed {
      logic take_byte;  // a request byte transfers this cycle
      logic start_div;  // that byte ends the key: launch the divider
      logic step_div;   // advance the divider by one quotient bit
      logic load_out;   // move the finished result into the output register
   } sjph_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic byte_last;  // last-byte flag of the offered request
      logic out_free;   // output register can take a result this cycle
   } sjph_status_type;

   function automatic logic is_lead(input logic [BYTE_W-1:0] b);
      return ((b >= LEAD_LO_A) && (b <= LEAD_HI_A)) ||
             ((b >= LEAD_LO_B) && (b <= LEAD_HI_B));
   endfunction

   function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
      if ((b >= UPPER_LO) && (b <= UPPER_HI)) begin
         return b + CASE_OFS;
      end
      return b;
   endfunction

   // One PJW/ELF round: shift in the character, fold the top nibble down
   // into bits 7:4 and clear it.
   function automatic logic [HASH_W-1:0] pjw_round(input logic [HASH_W-1:0] h,
                                                   input logic [CHAR_W-1:0] c);
      logic [HASH_W-1:0] sum;
      sum = {h[HASH_W-5:0], 4'b0000} + {{(HASH_W-CHAR_W){1'b0}}, c};
      return {4'b0000, sum[27:8], sum[7:4] ^ sum[31:28], sum[3:0]};
   endfunction

endpackage

### rtl/sjph_if.sv
// ----------------------------------------------------------------------------
// sjph_req_if / sjph_rsp_if
// Valid/ready channels for key bytes and hash results.
// ----------------------------------------------------------------------------
interface sjph_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] key_byte;
   logic       last_byte;

   modport source (output valid, output key_byte, output last_byte, input ready);
   modport sink   (input valid, input key_byte, input last_byte, output ready);
endinterface

interface sjph_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] hash_value;
   logic [30:0] bucket_index;

   modport source (output valid, output hash_value, output bucket_index, input ready);
   modport sink   (input valid, input hash_value, input bucket_index, output ready);
endinterface

### rtl/sjis_pjw_bucket_hash_unit.sv
// ----------------------------------------------------------------------------
// sjis_pjw_bucket_hash_unit
// PJW/ELF 32-bit hash of an SJIS key, one byte per transfer, with the
// hash reduced modulo a programmable bucket count at the end of each key.
//
//   channel   dir  handshake     payload
//   req_chan  in   valid/ready   key_byte[7:0], last_byte
//   rsp_chan  out  valid/ready   hash_value[31:0], bucket_index[30:0]
//   csr_*     in   write enable  write_data[30:0] -> bucket count
//
// A byte that does not end the key leaves the block ready again at once.
// The last byte is hashed and launches the restoring divider (one quotient
// bit per cycle); the result then waits in the finish state until the
// output register is free, and intake stays closed until it is loaded.
// Reset is synchronous: hash state clears, bucket count returns to 127.
// A stalled result holds in the output register while the next key's
// bytes stream in; only the hand-off of the following result waits for it.
// ----------------------------------------------------------------------------
module sjis_pjw_bucket_hash_unit
   import sjph_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   sjph_req_if.sink            req_chan,
   sjph_rsp_if.source          rsp_chan,
   input  logic                csr_write_enable,
   input  logic [BUCKET_W-1:0] csr_write_data
);

   sjph_cmd_type    cmd;
   sjph_status_type status;

   // Sequencer: accept bytes while idle, run the divider, hand off results.
   sjph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hash, divider, bucket count and output register.
   sjph_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_key_byte     (req_chan.key_byte),
      .req_last_byte    (req_chan.last_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_hash_value   (rsp_chan.hash_value),
      .rsp_bucket_index (rsp_chan.bucket_index)
   );

`ifndef SYNTHESIS
   // A transfer of a closing byte must stall intake while the divider runs.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.last_byte) |=> !req_chan.ready)
      else $error("intake open while divider runs");

   // Loading a result always presents it on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_chan.valid)
      else $error("loaded result not presented");

   // A result never appears without a load.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.load_out))
      else $error("result valid without load");
`endif

endmodule

### rtl/sjph_ctrl.sv
// ----------------------------------------------------------------------------
// sjph_ctrl
// Sequencer: byte intake, divider run, result hand-off.
// ----------------------------------------------------------------------------
module sjph_ctrl
   import sjph_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  sjph_status_type status,
   output sjph_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_byte = 1'b1;
               if (status.byte_last) begin
                  cmd.start_div = 1'b1;
                  step_in       = '0;
                  state_in      = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.step_div = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold the result until the output register frees up
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

### rtl/sjph_datapath.sv
// ----------------------------------------------------------------------------
// sjph_datapath
// Character assembly, PJW hash register, bit-serial restoring divider,
// bucket count register and output register.
// ----------------------------------------------------------------------------
module sjph_datapath
   import sjph_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  sjph_cmd_type        cmd,
   output sjph_status_type     status,
   input  logic [BYTE_W-1:0]   req_key_byte,
   input  logic                req_last_byte,
   input  logic                csr_write_enable,
   input  logic [BUCKET_W-1:0] csr_write_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [HASH_W-1:0]   rsp_hash_value,
   output logic [BUCKET_W-1:0] rsp_bucket_index
);

   logic [HASH_W-1:0]   hash_ff;
   logic [BYTE_W-1:0]   held_ff;
   logic                pending_ff;
   logic [BUCKET_W-1:0] buckets_ff;

   logic [HASH_W-1:0]   final_ff;
   logic [HASH_W-1:0]   quo_ff;
   logic [HASH_W-1:0]   rem_ff;
   logic [BUCKET_W-1:0] divisor_ff;

   logic                out_valid_ff;
   logic [HASH_W-1:0]   out_hash_ff;
   logic [BUCKET_W-1:0] out_bucket_ff;

   logic [CHAR_W-1:0]   char_val;
   logic                absorb;
   logic [HASH_W-1:0]   hash_in;
   logic [HASH_W-1:0]   rem_shift;
   logic [HASH_W-1:0]   rem_in;

   assign status.byte_last = req_last_byte;
   assign status.out_free  = !out_valid_ff || rsp_ready;

   // Character selection: trail byte after a held lead, else a single byte.
   always_comb begin
      absorb   = 1'b1;
      char_val = {{(CHAR_W-BYTE_W){1'b0}}, fold_case(req_key_byte)};
      if (pending_ff) begin
         char_val = {held_ff, req_key_byte};
      end else if (is_lead(req_key_byte) && !req_last_byte) begin
         absorb = 1'b0;
      end
      hash_in = absorb ? pjw_round(hash_ff, char_val) : hash_ff;
   end

   // One restoring step per cycle
   always_comb begin
      rem_shift = {rem_ff[HASH_W-2:0], quo_ff[HASH_W-1]};
      rem_in    = rem_shift;
      if (rem_shift >= {1'b0, divisor_ff}) begin
         rem_in = rem_shift - {1'b0, divisor_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff    <= '0;
         held_ff    <= '0;
         pending_ff <= 1'b0;
         buckets_ff <= RESET_BUCKETS;
      end else begin
         if (csr_write_enable) begin
            buckets_ff <= csr_write_data;
         end
         if (cmd.take_byte) begin
            if (req_last_byte) begin
               hash_ff    <= '0;
               held_ff    <= '0;
               pending_ff <= 1'b0;
            end else if (pending_ff) begin
               hash_ff    <= hash_in;
               held_ff    <= '0;
               pending_ff <= 1'b0;
            end else if (!absorb) begin
               held_ff    <= req_key_byte;
               pending_ff <= 1'b1;
            end else begin
               hash_ff <= hash_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_div) begin
         final_ff   <= hash_in;
         quo_ff     <= hash_in;
         rem_ff     <= '0;
         divisor_ff <= (buckets_ff == '0) ? BUCKET_W'(1) : buckets_ff;
      end else if (cmd.step_div) begin
         quo_ff <= {quo_ff[HASH_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_hash_ff   <= final_ff;
         out_bucket_ff <= rem_ff[BUCKET_W-1:0];
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_hash_value   = out_hash_ff;
   assign rsp_bucket_index = out_bucket_ff;

endmodule

### verif/tb_sjis_pjw_bucket_hash_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sjis_pjw_bucket_hash_unit
// Self-checking bench for the SJIS PJW bucket hash unit. Keys stream in
// byte by byte. A behavioral copy of the hash and bucket arithmetic predicts
// every result, and each returned transfer is checked against it. Directed
// keys cover the character-class corners. Random keys then run under several
// bucket counts and several sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_sjis_pjw_bucket_hash_unit;
   import sjph_pkg::*;

   localparam int CLOCK_HALF    = 5;
   localparam int RESET_CYCLES  = 9;
   localparam int DRAIN_CYCLES  = 40;       // idle margin after a drain, past the divider run
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int PHASE_BYTES   = 310;
   localparam int RANDOM_PHASES = 6;
   localparam int LONG_HOLD     = 300;

   typedef struct {
      logic [BYTE_W-1:0] key_byte;
      logic              last_byte;
   } key_byte_item_type;

   typedef struct {
      logic [HASH_W-1:0]   hash_value;
      logic [BUCKET_W-1:0] bucket_index;
   } hash_result_type;

   logic                clock;
   logic                reset;
   logic                csr_write_enable;
   logic [BUCKET_W-1:0] csr_write_data;

   sjph_req_if req_chan ();
   sjph_rsp_if rsp_chan ();

   sjis_pjw_bucket_hash_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Bytes waiting to be offered, and results the hash model has produced
   // but the block has not yet returned.
   key_byte_item_type pending_bytes[$];
   hash_result_type   hash_expect[$];

   // Hash model state
   logic [HASH_W-1:0]   key_hash;
   logic [BYTE_W-1:0]   held_lead;
   logic                lead_held;
   logic [BUCKET_W-1:0] bucket_div;

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  send_idle_pct  = 0;
   int  recv_idle_pct  = 0;
   int  stall_request  = 0;
   int  hold_left      = 0;
   logic req_taken     = 1'b0;

   // -------------------------------------------------------------------------
   // Hash model helpers
   // -------------------------------------------------------------------------
   function automatic logic in_lead_range(input logic [BYTE_W-1:0] b);
      return (b >= LEAD_LO_A && b <= LEAD_HI_A) || (b >= LEAD_LO_B && b <= LEAD_HI_B);
   endfunction

   // Fold ASCII capitals only; everything else passes untouched.
   function automatic logic [BYTE_W-1:0] ascii_lower(input logic [BYTE_W-1:0] b);
      if (b >= UPPER_LO && b <= UPPER_HI) begin
         return b + CASE_OFS;
      end
      return b;
   endfunction

   // Shift in one character, then fold any top nibble down to bits 7:4 and
   // clear it.
   function automatic logic [HASH_W-1:0] pjw_mix(input logic [HASH_W-1:0] h,
                                                 input logic [CHAR_W-1:0] c);
      logic [HASH_W-1:0] acc;
      logic [HASH_W-1:0] top;
      acc = (h << 4) + {{(HASH_W-CHAR_W){1'b0}}, c};
      top = acc & 32'hF000_0000;
      if (top != '0) begin
         acc = acc ^ (top >> 24) ^ top;
      end
      return acc;
   endfunction

   // -------------------------------------------------------------------------
   // Clock
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Watchdog: any hang or lost result ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sjis_pjw_bucket_hash_unit: mismatch");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Request driver: offer the next pending byte once the current one has
   // transferred (or nothing is offered), idling at the current rate.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin : drive_req
      key_byte_item_type item;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            item = pending_bytes.pop_front();
            req_chan.valid     <= 1'b1;
            req_chan.key_byte  <= item.key_byte;
            req_chan.last_byte <= item.last_byte;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result receiver: a requested long hold-off takes priority over the
   // random back-pressure; count it down here, one cycle per falling edge.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_request > 0) begin
         hold_left     = stall_request;
         stall_request = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: check returned results, then advance the hash model with any
   // byte that transferred at this edge. A byte transferred now can't have
   // its result out at the same edge, so the order is safe.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : watch
      hash_result_type   want;
      logic [HASH_W-1:0] divisor;
      logic [HASH_W-1:0] remainder;
      logic [BYTE_W-1:0] b;
      if (reset) begin
         key_hash   = '0;
         held_lead  = '0;
         lead_held  = 1'b0;
         bucket_div = RESET_BUCKETS;
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_chan.valid && req_chan.ready;

         if (csr_write_enable) begin
            bucket_div = csr_write_data;
         end

         if (rsp_chan.valid && rsp_chan.ready) begin
            if (hash_expect.size() == 0) begin
               $error("unexpected result: hash_value %h bucket_index %h",
                      rsp_chan.hash_value, rsp_chan.bucket_index);
               mismatch_count++;
            end else begin
               want = hash_expect.pop_front();
               if (rsp_chan.hash_value !== want.hash_value) begin
                  $error("hash_value: expected %h, got %h",
                         want.hash_value, rsp_chan.hash_value);
                  mismatch_count++;
               end
               if (rsp_chan.bucket_index !== want.bucket_index) begin
                  $error("bucket_index: expected %h, got %h",
                         want.bucket_index, rsp_chan.bucket_index);
                  mismatch_count++;
               end
            end
         end

         if (req_chan.valid && req_chan.ready) begin
            b = req_chan.key_byte;
            if (lead_held) begin
               // Trail byte: taken raw, whatever its value, never folded.
               key_hash  = pjw_mix(key_hash, {held_lead, b});
               held_lead = '0;
               lead_held = 1'b0;
            end else if (in_lead_range(b) && !req_chan.last_byte) begin
               held_lead = b;
               lead_held = 1'b1;
            end else begin
               // Single-byte character, including a lead byte that ends the key.
               key_hash = pjw_mix(key_hash, {8'h00, ascii_lower(b)});
            end

            if (req_chan.last_byte) begin
               // A zero bucket count divides as one.
               divisor   = (bucket_div == '0) ? 32'd1 : {1'b0, bucket_div};
               remainder = key_hash % divisor;
               want.hash_value   = key_hash;
               want.bucket_index = remainder[BUCKET_W-1:0];
               hash_expect.insert(hash_expect.size(), want);
               key_hash  = '0;
               held_lead = '0;
               lead_held = 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic last);
      key_byte_item_type item;
      item.key_byte  = b;
      item.last_byte = last;
      pending_bytes.insert(pending_bytes.size(), item);
   endtask

   // Build one well-formed key of random content: mostly short, now and then
   // long enough to churn the top nibble many times. Some raw random bytes
   // slip in as noise and may pair up or end as a lone lead byte.
   task automatic queue_random_key(inout int byte_total);
      int                n_chars;
      int                kind;
      logic              last;
      logic [BYTE_W-1:0] lead;
      n_chars = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      for (int k = 0; k < n_chars; k++) begin
         kind = $urandom_range(9);
         last = (k == n_chars - 1);
         if (kind < 4) begin
            queue_byte(BYTE_W'($urandom_range(8'h7E, 8'h20)), last);
            byte_total += 1;
         end else if (kind < 7) begin
            lead = ($urandom_range(1) == 0) ? BYTE_W'($urandom_range(LEAD_HI_A, LEAD_LO_A))
                                            : BYTE_W'($urandom_range(LEAD_HI_B, LEAD_LO_B));
            queue_byte(lead, 1'b0);
            queue_byte(BYTE_W'($urandom_range(8'hFF, 8'h00)), last);
            byte_total += 2;
         end else begin
            queue_byte(BYTE_W'($urandom_range(8'hFF, 8'h00)), last);
            byte_total += 1;
         end
      end
   endtask

   // Hold until every byte has transferred and every result has come back,
   // then give the divider time to go quiet.
   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_chan.valid || hash_expect.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_buckets(input logic [BUCKET_W-1:0] count);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= count;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin : run
      int                  byte_total;
      logic [BUCKET_W-1:0] count;

      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;
      req_chan.valid     = 1'b0;
      req_chan.key_byte  = '0;
      req_chan.last_byte = 1'b0;
      rsp_chan.ready     = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed keys under the reset bucket count.
      send_idle_pct = 6;
      recv_idle_pct = 65;
      queue_byte(8'h00, 1'b1);                   // smallest byte alone
      queue_byte(8'hFF, 1'b1);                   // largest byte alone
      queue_byte(8'h41, 1'b0);                   // capitals fold; neighbors don't
      queue_byte(8'h5A, 1'b0);
      queue_byte(8'h40, 1'b0);
      queue_byte(8'h5B, 1'b0);
      queue_byte(8'h7A, 1'b1);
      queue_byte(8'h81, 1'b1);                   // lead byte that ends the key
      queue_byte(8'h81, 1'b0);                   // trail 'A' stays unfolded
      queue_byte(8'h41, 1'b0);
      queue_byte(8'h9F, 1'b0);                   // trail that is itself a lead
      queue_byte(8'hE0, 1'b0);
      queue_byte(8'hFC, 1'b0);
      queue_byte(8'h5A, 1'b0);
      queue_byte(8'h80, 1'b0);                   // just outside both lead ranges
      queue_byte(8'hA0, 1'b0);
      queue_byte(8'hDF, 1'b0);
      queue_byte(8'hFD, 1'b1);
      queue_byte(8'h7F, 1'b0);
      queue_byte(8'hFE, 1'b0);
      queue_byte(8'h20, 1'b0);
      queue_byte(8'hE0, 1'b0);                   // key ends on a trail byte
      queue_byte(8'hFF, 1'b1);
      wait_drained();

      for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
         case (phase)
            1: count = 31'd1;
            2: count = 31'h7FFF_FFFF;
            3: count = 31'd0;
            4: count = 31'd2;
            5: count = BUCKET_W'($urandom_range(32'h7FFF_FFFF, 1));
            default: count = BUCKET_W'($urandom_range(5000, 3));
         endcase
         write_buckets(count);
         @(posedge clock);

         // Sender rarely idles first, then the receiver rarely idles, then
         // neither idles at all.
         if (phase <= 2) begin
            send_idle_pct = 6;
            recv_idle_pct = 65;
         end else if (phase <= 4) begin
            send_idle_pct = 65;
            recv_idle_pct = 6;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         // Back up the result side for a long stretch while bytes keep
         // coming, so the block fills and stalls its input.
         if (phase == 3 || phase == 5) begin
            stall_request = LONG_HOLD;
         end

         byte_total = 0;
         while (byte_total < PHASE_BYTES) begin
            queue_random_key(byte_total);
         end
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("sjis_pjw_bucket_hash_unit: match");
      end else begin
         $display("sjis_pjw_bucket_hash_unit: mismatch");
      end
      $finish;
   end

endmodule
